// ===== src/sap_pkg.sv =====
// Shared constants, types and the quarter-wave sine builder for the auto-panner.
// No dependencies; used by sap_sine_rom, sap_lfo, sap_lane, sap_merge and the top level.
package sap_pkg;

    localparam int GAIN_BITS   = 16;
    localparam int ROUND_SHIFT = 15;
    localparam int MAG_BITS    = 15;
    localparam int STEP_BITS   = 31;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 31'd89478;
    localparam logic [MAG_BITS-1:0]  MAG_MAX    = 15'd32767;

    localparam longint unsigned COEF_A = 64'd1686629713;
    localparam longint unsigned COEF_B = 64'd693598668;
    localparam longint unsigned COEF_C = 64'd85569306;
    localparam longint unsigned COEF_D = 64'd5026997;
    localparam longint unsigned COEF_E = 64'd172272;

    typedef struct packed {
        logic load_gain;
        logic load_prod;
    } lane_ctrl_t;

    function automatic logic [MAG_BITS-1:0] sine_mag(int unsigned r, int unsigned tbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned y;
        x  = longint'(r) << (30 - (tbits - 2));
        x2 = (x * x) >> 30;
        p  = COEF_E;
        p  = COEF_D - ((x2 * p) >> 30);
        p  = COEF_C - ((x2 * p) >> 30);
        p  = COEF_B - ((x2 * p) >> 30);
        p  = COEF_A - ((x2 * p) >> 30);
        y  = (x * p) >> 30;
        y  = (y + 64'd16384) >> 15;
        if (y > 64'd32767)
        begin
            y = 64'd32767;
        end
        return y[MAG_BITS-1:0];
    endfunction

endpackage

// ===== src/sap_in_if.sv =====
// Input request channel: one stereo sample pair with valid/ready handshake.
// No dependencies.
interface sap_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ===== src/sap_out_if.sv =====
// Output request channel: one panned stereo sample pair with valid/ready handshake.
// No dependencies.
interface sap_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== src/sap_sine_rom.sv =====
// Full-wave sine lookup from a quarter-wave constant table, registered read, Q1.15.
// Depends on sap_pkg (sine_mag, widths).
module sap_sine_rom #(
    parameter int TBITS = 10
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [TBITS-1:0]                    idx,
    output logic signed [sap_pkg::GAIN_BITS-1:0] gain
);

    localparam int QUARTER = 1 << (TBITS - 2);
    localparam logic [TBITS-2:0] QTR = (TBITS-1)'(QUARTER);

    typedef logic [sap_pkg::MAG_BITS-1:0] rom_t [QUARTER+1];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i <= QUARTER; i++)
        begin
            t[i] = sap_pkg::sine_mag(i, TBITS);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [1:0]                          quad;
    logic [TBITS-2:0]                    addr;
    logic signed [sap_pkg::GAIN_BITS-1:0] mag;
    logic signed [sap_pkg::GAIN_BITS-1:0] gain_reg;

    assign quad = idx[TBITS-1:TBITS-2];

    always_comb
    begin
        if (quad[0])
        begin
            addr = QTR - {1'b0, idx[TBITS-3:0]};
        end
        else
        begin
            addr = {1'b0, idx[TBITS-3:0]};
        end
    end

    assign mag = $signed({1'b0, ROM[addr]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gain_reg <= quad[1] ? -mag : mag;
        end
    end

    assign gain = gain_reg;

endmodule

// ===== src/sap_lfo.sv =====
// Phase accumulator and LFO sine lookup; holds the phase step register.
// Depends on sap_pkg and sap_sine_rom.
module sap_lfo #(
    parameter int PHASE_BITS = 32,
    parameter int TBITS      = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sap_pkg::STEP_BITS-1:0]        cfg_wdata,
    input  logic                                 load,
    input  logic                                 advance,
    output logic signed [sap_pkg::GAIN_BITS-1:0] lfo_gain
);

    logic [sap_pkg::STEP_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [PHASE_BITS-1:0]         phase_next;

    assign phase_next = phase_reg + PHASE_BITS'(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= sap_pkg::STEP_RESET;
            phase_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    sap_sine_rom #(.TBITS(TBITS)) u_rom (
        .clk  (clk),
        .en   (load),
        .idx  (phase_reg[PHASE_BITS-1 -: TBITS]),
        .gain (lfo_gain)
    );

endmodule

// ===== src/sap_lane.sv =====
// One channel lane: pan gain lookup, then sample times gain.
// Depends on sap_pkg and sap_sine_rom.
module sap_lane #(
    parameter int   SAMPLE_BITS = 24,
    parameter int   TBITS       = 10,
    parameter bit   COS_LANE    = 1'b0
) (
    input  logic                                              clk,
    input  sap_pkg::lane_ctrl_t                               ctrl,
    input  logic [TBITS-1:0]                                  angle,
    input  logic signed [SAMPLE_BITS-1:0]                     sample,
    output logic signed [SAMPLE_BITS+sap_pkg::GAIN_BITS-1:0]  prod
);

    localparam int PW = SAMPLE_BITS + sap_pkg::GAIN_BITS;
    localparam logic [TBITS-1:0] QTR = TBITS'(1 << (TBITS - 2));

    logic [TBITS-1:0]                     idx;
    logic signed [sap_pkg::GAIN_BITS-1:0] gain;
    logic signed [SAMPLE_BITS-1:0]        sample_reg;
    logic signed [PW-1:0]                 prod_reg;

    assign idx = COS_LANE ? angle + QTR : angle;

    sap_sine_rom #(.TBITS(TBITS)) u_rom (
        .clk  (clk),
        .en   (ctrl.load_gain),
        .idx  (idx),
        .gain (gain)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load_gain)
        begin
            sample_reg <= sample;
        end
        if (ctrl.load_prod)
        begin
            prod_reg <= PW'(sample_reg) * PW'(gain);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/sap_merge.sv =====
// Output stage: round both lane products to the sample format and saturate.
// Depends on sap_pkg.
module sap_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                             clk,
    input  logic                                             load,
    input  logic signed [SAMPLE_BITS+sap_pkg::GAIN_BITS-1:0] prod_left,
    input  logic signed [SAMPLE_BITS+sap_pkg::GAIN_BITS-1:0] prod_right,
    output logic signed [SAMPLE_BITS-1:0]                    left_out,
    output logic signed [SAMPLE_BITS-1:0]                    right_out
);

    localparam int PW = SAMPLE_BITS + sap_pkg::GAIN_BITS;
    localparam logic signed [PW:0] SMAX = (PW+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW:0] SMIN = (PW+1)'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [PW:0] HALF = (PW+1)'(1 << (sap_pkg::ROUND_SHIFT - 1));

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(logic signed [PW-1:0] p);
        logic signed [PW:0] v;
        logic signed [PW:0] r;
        v = (PW+1)'(p) + HALF;
        r = v >>> sap_pkg::ROUND_SHIFT;
        if (r > SMAX)
        begin
            r = SMAX;
        end
        else if (r < SMIN)
        begin
            r = SMIN;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= round_sat(prod_left);
            right_reg <= round_sat(prod_right);
        end
    end

    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule

// ===== src/sine_lfo_constant_power_autopan.sv =====
// Constant-power auto-panner with sine LFO: top level, pipeline control and lanes.
// Depends on sap_pkg, sap_in_if, sap_out_if, sap_lfo, sap_lane, sap_merge.
// Pipeline: 4 stages (input and LFO lookup, gain, product, output), each registered in that order.
// Throughput: one stereo pair per cycle while the output is ready; each stage stalls only when the one after is full.
// Reset: phase cleared, phase step set to 89478, pipeline emptied.
module sine_lfo_constant_power_autopan #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sap_pkg::STEP_BITS-1:0] cfg_wdata,
    sap_in_if.sink                        in_stream,
    sap_out_if.source                     out_stream
);

    localparam int TB = SINE_TABLE_BITS;
    localparam int PW = SAMPLE_BITS + sap_pkg::GAIN_BITS;
    localparam int MW = 19 + TB;
    localparam logic [MW-1:0] ANGLE_ROUND = MW'(1 << 17);

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic vo_reg;
    logic adv1;
    logic adv2;
    logic adv3;
    logic advo;
    logic accept;

    logic signed [SAMPLE_BITS-1:0]        s1_left_reg;
    logic signed [SAMPLE_BITS-1:0]        s1_right_reg;
    logic signed [sap_pkg::GAIN_BITS-1:0] lfo_gain;
    logic [MW-1:0]                        angle_sum;
    logic [TB-1:0]                        angle;
    logic signed [PW-1:0]                 prod_left;
    logic signed [PW-1:0]                 prod_right;
    sap_pkg::lane_ctrl_t                  lane_ctrl;

    assign advo   = !vo_reg || out_stream.ready;
    assign adv3   = !v3_reg || advo;
    assign adv2   = !v2_reg || adv3;
    assign adv1   = !v1_reg || adv2;
    assign accept = in_stream.valid && adv1;

    assign in_stream.ready  = adv1;
    assign out_stream.valid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_stream.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (advo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_left_reg  <= in_stream.left_in;
            s1_right_reg <= in_stream.right_in;
        end
    end

    sap_lfo #(
        .PHASE_BITS (PHASE_BITS),
        .TBITS      (TB)
    ) u_lfo (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .load      (adv1),
        .advance   (accept),
        .lfo_gain  (lfo_gain)
    );

    // map the LFO value to a pan angle in the first quarter turn
    assign angle_sum = (MW'({~lfo_gain[sap_pkg::GAIN_BITS-1],
                             lfo_gain[sap_pkg::GAIN_BITS-2:0]}) << TB) + ANGLE_ROUND;
    assign angle     = angle_sum[18 +: TB];

    assign lane_ctrl.load_gain = adv2;
    assign lane_ctrl.load_prod = adv3;

    sap_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TBITS       (TB),
        .COS_LANE    (1'b1)
    ) u_lane_left (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .angle  (angle),
        .sample (s1_left_reg),
        .prod   (prod_left)
    );

    sap_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TBITS       (TB),
        .COS_LANE    (1'b0)
    ) u_lane_right (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .angle  (angle),
        .sample (s1_right_reg),
        .prod   (prod_right)
    );

    sap_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .clk        (clk),
        .load       (advo),
        .prod_left  (prod_left),
        .prod_right (prod_right),
        .left_out   (out_stream.left_out),
        .right_out  (out_stream.right_out)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted request not in first stage");

    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !adv3 |=> v2_reg)
        else $error("stalled gain stage lost its request");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && vo_reg && !out_stream.ready |=> v3_reg && vo_reg)
        else $error("stalled product stage lost its request");

endmodule
